// ===== rtl/mlss_pkg.sv =====
// ----------------------------------------------------------------------------
// mlss_pkg
// Shared types, codes and decode tables for the MIPS logic-subset step unit.
// ----------------------------------------------------------------------------
package mlss_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned GPR_NUM  = 32;
  localparam int unsigned GPR_AW   = 5;
  localparam int unsigned ID_W     = 7;
  localparam int unsigned MEMSZ_W  = 24;
  localparam int unsigned CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_PC   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_BYTES  = 1'd1;

  localparam logic [XLEN-1:0]    START_PC_RST  = 32'd0;
  localparam logic [MEMSZ_W-1:0] MEM_BYTES_RST = 24'd4194304;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;

  // identities that are executed
  localparam logic [ID_W-1:0] ID_UNKNOWN = 7'd0;
  localparam logic [ID_W-1:0] ID_AND     = 7'd33;
  localparam logic [ID_W-1:0] ID_OR      = 7'd34;
  localparam logic [ID_W-1:0] ID_XOR     = 7'd35;
  localparam logic [ID_W-1:0] ID_NOR     = 7'd36;
  localparam logic [ID_W-1:0] ID_ANDI    = 7'd79;
  localparam logic [ID_W-1:0] ID_ORI     = 7'd80;
  localparam logic [ID_W-1:0] ID_XORI    = 7'd81;

  typedef enum logic [1:0] {
    ST_STEPPED     = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_UNALIGNED   = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   identity;
    logic [XLEN-1:0]   next_pc;
    logic              reg_written;
    logic [GPR_AW-1:0] dest_reg;
    logic [XLEN-1:0]   dest_value;
  } res_t;

  localparam logic [ID_W-1:0] SPECIAL_IDS [64] = '{
    7'd3,  7'd1,  7'd4,  7'd5,  7'd6,  7'd1,  7'd7,  7'd8,
    7'd9,  7'd10, 7'd1,  7'd1,  7'd11, 7'd12, 7'd1,  7'd13,
    7'd14, 7'd15, 7'd16, 7'd17, 7'd18, 7'd1,  7'd19, 7'd20,
    7'd21, 7'd22, 7'd23, 7'd24, 7'd25, 7'd26, 7'd27, 7'd28,
    7'd29, 7'd30, 7'd31, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36,
    7'd1,  7'd1,  7'd37, 7'd38, 7'd39, 7'd40, 7'd41, 7'd42,
    7'd43, 7'd44, 7'd45, 7'd46, 7'd47, 7'd1,  7'd48, 7'd1,
    7'd49, 7'd1,  7'd50, 7'd51, 7'd52, 7'd1,  7'd53, 7'd54};

  localparam logic [ID_W-1:0] REGIMM_IDS [32] = '{
    7'd55, 7'd56, 7'd57, 7'd58, 7'd2,  7'd2,  7'd2,  7'd2,
    7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd2,  7'd64, 7'd2,
    7'd65, 7'd66, 7'd67, 7'd68, 7'd2,  7'd2,  7'd2,  7'd2,
    7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2,  7'd2};

  localparam logic [ID_W-1:0] PRIMARY_IDS [64] = '{
    7'd0,   7'd0,   7'd69,  7'd70,  7'd71,  7'd72,  7'd73,  7'd74,
    7'd75,  7'd76,  7'd77,  7'd78,  7'd79,  7'd80,  7'd81,  7'd82,
    7'd83,  7'd84,  7'd85,  7'd86,  7'd87,  7'd88,  7'd89,  7'd90,
    7'd91,  7'd92,  7'd93,  7'd94,  7'd0,   7'd0,   7'd0,   7'd0,
    7'd95,  7'd96,  7'd97,  7'd98,  7'd99,  7'd100, 7'd101, 7'd102,
    7'd103, 7'd104, 7'd105, 7'd106, 7'd107, 7'd108, 7'd109, 7'd110,
    7'd111, 7'd112, 7'd113, 7'd0,   7'd114, 7'd115, 7'd116, 7'd117,
    7'd118, 7'd119, 7'd120, 7'd0,   7'd121, 7'd122, 7'd123, 7'd124};

  function automatic logic [ID_W-1:0] mlss_classify(input logic [XLEN-1:0] word);
    logic [ID_W-1:0] id;
    if (word[31:26] == OP_SPECIAL) begin
      id = SPECIAL_IDS[word[5:0]];
    end else if (word[31:26] == OP_REGIMM) begin
      id = REGIMM_IDS[word[20:16]];
    end else begin
      id = PRIMARY_IDS[word[31:26]];
    end
    return id;
  endfunction

endpackage

// ===== rtl/mips_logic_subset_step_unit.sv =====
// ----------------------------------------------------------------------------
// mips_logic_subset_step_unit
// Steps a MIPS III logic subset one instruction word at a time.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | in_instr_word
//  out_    | output    | out_valid / out_ready | status, identity, pcs, dest
//  cfg_    | input     | cfg_wr_en             | cfg_index, cfg_wdata
//
//  One instruction per cycle sustained while out_ready is high; an input beat
//  passes the operand register stage, then the result register.
//  The register file read is issued as the word is taken, so the RAM's
//  registered read port sets the first stage; a write from the executing
//  instruction is bypassed into it.
//  Reset: PC and memory size take their reset values, all registers read 0.
//  A stalled result holds the result register; the input stage keeps
//  accepting while it has room.
// ----------------------------------------------------------------------------
module mips_logic_subset_step_unit
  import mlss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [XLEN-1:0]      in_instr_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [ID_W-1:0]      out_identity,
  output logic [XLEN-1:0]      out_fetch_pc,
  output logic [XLEN-1:0]      out_next_pc,
  output logic                 out_reg_written,
  output logic [GPR_AW-1:0]    out_dest_reg,
  output logic [XLEN-1:0]      out_dest_value,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [XLEN-1:0]      cfg_wdata
);

  logic               s1_valid_r;
  logic [XLEN-1:0]    s1_word_r;
  logic               out_valid_r;
  res_t               out_res_r;
  logic [XLEN-1:0]    out_pc_r;
  logic [XLEN-1:0]    pc_r;
  logic [MEMSZ_W-1:0] mem_bytes_r;
  logic               accept, advance;
  logic [XLEN-1:0]    rs_val, rt_val;
  res_t               res;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign accept   = in_valid && in_ready;

  mlss_gpr u_gpr (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rs_addr (in_instr_word[25:21]),
    .rt_addr (in_instr_word[20:16]),
    .wr_en   (advance && res.reg_written),
    .wr_addr (res.dest_reg),
    .wr_data (res.dest_value),
    .rs_data (rs_val),
    .rt_data (rt_val)
  );

  mlss_exec u_exec (
    .pc        (pc_r),
    .mem_bytes (mem_bytes_r),
    .word      (s1_word_r),
    .rs_val    (rs_val),
    .rt_val    (rt_val),
    .res       (res)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r <= in_instr_word;
    end
  end

  // architectural state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= START_PC_RST;
      mem_bytes_r <= MEM_BYTES_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_START_PC:  pc_r <= cfg_wdata;
        REG_MEM_BYTES: mem_bytes_r <= cfg_wdata[MEMSZ_W-1:0];
        default: ;
      endcase
    end else if (advance && (res.status == ST_STEPPED)) begin
      pc_r <= res.next_pc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
      out_pc_r  <= pc_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_identity    = out_res_r.identity;
  assign out_fetch_pc    = out_pc_r;
  assign out_next_pc     = out_res_r.next_pc;
  assign out_reg_written = out_res_r.reg_written;
  assign out_dest_reg    = out_res_r.dest_reg;
  assign out_dest_value  = out_res_r.dest_value;

endmodule

// ===== rtl/mlss_ram.sv =====
// ----------------------------------------------------------------------------
// mlss_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module mlss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== rtl/mlss_gpr.sv =====
// ----------------------------------------------------------------------------
// mlss_gpr
// General register file: RAM plus per-entry valid bits and write bypass.
// ----------------------------------------------------------------------------
module mlss_gpr
  import mlss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [GPR_AW-1:0] rs_addr,
  input  logic [GPR_AW-1:0] rt_addr,
  input  logic              wr_en,
  input  logic [GPR_AW-1:0] wr_addr,
  input  logic [XLEN-1:0]   wr_data,
  output logic [XLEN-1:0]   rs_data,
  output logic [XLEN-1:0]   rt_data
);

  logic [GPR_NUM-1:0] valid_r;
  logic               rs_vld_r, rt_vld_r;
  logic               rs_fwd_r, rt_fwd_r;
  logic [XLEN-1:0]    fwd_data_r;
  logic [XLEN-1:0]    ram_rs, ram_rt;

  mlss_ram #(
    .WIDTH (XLEN),
    .DEPTH (GPR_NUM)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (rs_addr),
    .rd_addr_b (rt_addr),
    .rd_data_a (ram_rs),
    .rd_data_b (ram_rt)
  );

  // unwritten entries read as zero; r0 is never written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // take the value being written in the same cycle as the read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rs_vld_r   <= valid_r[rs_addr];
      rt_vld_r   <= valid_r[rt_addr];
      rs_fwd_r   <= wr_en && (wr_addr == rs_addr);
      rt_fwd_r   <= wr_en && (wr_addr == rt_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rs_data = rs_fwd_r ? fwd_data_r : (rs_vld_r ? ram_rs : '0);
  assign rt_data = rt_fwd_r ? fwd_data_r : (rt_vld_r ? ram_rt : '0);

endmodule

// ===== rtl/mlss_exec.sv =====
// ----------------------------------------------------------------------------
// mlss_exec
// Fetch check, classification and logic-operation execute for one word.
// ----------------------------------------------------------------------------
module mlss_exec
  import mlss_pkg::*;
(
  input  logic [XLEN-1:0]    pc,
  input  logic [MEMSZ_W-1:0] mem_bytes,
  input  logic [XLEN-1:0]    word,
  input  logic [XLEN-1:0]    rs_val,
  input  logic [XLEN-1:0]    rt_val,
  output res_t               res
);

  logic [ID_W-1:0]   id;
  logic [XLEN:0]     fetch_end;
  logic [XLEN-1:0]   imm;
  logic [GPR_AW-1:0] rt, rd;
  logic              done;
  logic [GPR_AW-1:0] dest;
  logic [XLEN-1:0]   val;

  assign id        = mlss_classify(word);
  assign fetch_end = {1'b0, pc} + (XLEN+1)'(4);
  assign imm       = {16'd0, word[15:0]};
  assign rt        = word[20:16];
  assign rd        = word[15:11];

  always_comb begin
    done = 1'b1;
    dest = rd;
    val  = '0;
    case (id)
      ID_AND:  val = rs_val & rt_val;
      ID_OR:   val = rs_val | rt_val;
      ID_XOR:  val = rs_val ^ rt_val;
      ID_NOR:  val = ~(rs_val | rt_val);
      ID_ANDI: begin dest = rt; val = rs_val & imm; end
      ID_ORI:  begin dest = rt; val = rs_val | imm; end
      ID_XORI: begin dest = rt; val = rs_val ^ imm; end
      default: begin done = 1'b0; dest = '0; end
    endcase
  end

  always_comb begin
    res.status      = ST_STEPPED;
    res.identity    = ID_UNKNOWN;
    res.next_pc     = pc;
    res.reg_written = 1'b0;
    res.dest_reg    = '0;
    res.dest_value  = '0;
    if (pc[1:0] != 2'b00) begin
      res.status = ST_UNALIGNED;
    end else if (fetch_end > {9'd0, mem_bytes}) begin
      res.status = ST_OUT_OF_RANGE;
    end else begin
      res.identity = id;
      if (done) begin
        res.next_pc     = fetch_end[XLEN-1:0];
        res.reg_written = (dest != '0);
        res.dest_reg    = dest;
        res.dest_value  = val;
      end else begin
        res.status = ST_UNSUPPORTED;
      end
    end
  end

endmodule

// ===== rtl/mlss_checker.sv =====
// ----------------------------------------------------------------------------
// mlss_checker
// Port-level checks on the step unit's result beats.
// ----------------------------------------------------------------------------
module mlss_checker
  import mlss_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           out_status,
  input logic [ID_W-1:0]      out_identity,
  input logic [XLEN-1:0]      out_fetch_pc,
  input logic [XLEN-1:0]      out_next_pc,
  input logic                 out_reg_written,
  input logic [GPR_AW-1:0]    out_dest_reg,
  input logic [XLEN-1:0]      out_dest_value
);

  // a stepped beat advances the PC by one word
  a_step_pc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_STEPPED) |-> out_next_pc == out_fetch_pc + 32'd4)
    else $error("stepped beat does not advance PC by 4");

  // anything else leaves the PC and registers alone
  a_hold_pc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_STEPPED)
      |-> (out_next_pc == out_fetch_pc) && !out_reg_written && (out_dest_value == '0))
    else $error("non-stepped beat changes state");

  // a register write is never to r0
  a_no_r0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reg_written |-> (out_dest_reg != '0) && (out_status == ST_STEPPED))
    else $error("register write reported to r0 or on a failed step");

  // fetch faults carry no identity
  a_fault_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ST_UNALIGNED) || (out_status == ST_OUT_OF_RANGE))
      |-> (out_identity == ID_UNKNOWN) && (out_dest_reg == '0))
    else $error("fetch fault beat carries decode fields");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc) && $stable(out_dest_value))
    else $error("stalled result beat changed");

endmodule

bind mips_logic_subset_step_unit mlss_checker u_mlss_checker (.*);
